// File: design/rsh_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rsh_pkg: shared types and constants for the range scaled histogram
// Holds payload structs, the sequencer state type and the counter port struct.
// ============================================================================
package rsh_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int BINS_W          = 7;
   localparam int BIN_IDX_W       = 6;
   localparam int TOTAL_W         = 11;
   localparam int MAX_BINS        = 64;
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int NUM_BINS_RESET  = 8;

   // numerator of the bin quotient is (x - min) * bins
   localparam int RANGE_W = SAMPLE_W;
   localparam int PROD_W  = RANGE_W + BINS_W;
   localparam int QUOT_W  = BINS_W;
   localparam int STEP_W  = $clog2(QUOT_W);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic [BIN_IDX_W-1:0] bin_index;
      logic [TOTAL_W-1:0]   bin_total;
      logic                 last_bin;
      logic                 overflowed;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic                 clr_en;
      logic [BIN_IDX_W-1:0] rd_addr;
      logic [BIN_IDX_W-1:0] wr_addr;
      logic [TOTAL_W-1:0]   wr_data;
   } cnt_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RANGE,
      ST_FETCH,
      ST_MUL,
      ST_DIV,
      ST_CNT_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

// File: design/rsh_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// rsh_divider: iterative restoring divider for the bin quotient
// One quotient bit per cycle; the quotient is known to stay below 2**QUOT_W.
// ============================================================================
module rsh_divider
   import rsh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PROD_W-1:0]  numerator,
   input  logic [RANGE_W-1:0] denominator,
   output logic               done,
   output logic [QUOT_W-1:0]  quotient
);

   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] dvs_ff, dvs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numerator;
         dvs_in  = PROD_W'(denominator) << (QUOT_W - 1);
         quot_in = '0;
         step_in = STEP_W'(QUOT_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         // subtract the shifted divisor where it fits
         if (rem_ff >= dvs_ff) begin
            rem_in  = rem_ff - dvs_ff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: design/rsh_bin_counter.sv
`timescale 1ns / 1ps
// ============================================================================
// rsh_bin_counter: per-bin sample counts
// Count memory with registered read; an entry without its valid bit reads zero.
// ============================================================================
module rsh_bin_counter
   import rsh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cnt_ctrl_type       ctrl,
   output logic [TOTAL_W-1:0] rd_data
);

   logic [TOTAL_W-1:0]  count_mem_ff [MAX_BINS];
   logic [MAX_BINS-1:0] valid_ff;
   logic [TOTAL_W-1:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         count_mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= valid_ff[ctrl.rd_addr] ? count_mem_ff[ctrl.rd_addr] : '0;
      end
   end

   // clear drops the entry back to zero after it has been emitted
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[ctrl.wr_addr] <= 1'b1;
      end else if (ctrl.clr_en) begin
         valid_ff[ctrl.wr_addr] <= 1'b0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/range_scaled_histogram_core.sv
`timescale 1ns / 1ps
// ============================================================================
// range_scaled_histogram_core: equal-width min/max histogram of a sample set
// Buffers signed samples, then bins them between their minimum and maximum.
// ============================================================================
// Usage:
//  - Input: a transfer is taken at a clock edge with start high and busy low.
//    Each sample is written to the sample store in that cycle and the running
//    minimum and maximum advance; busy stays low while loading, so one sample
//    per cycle is taken. Samples beyond MAX_SAMPLES are dropped and flagged.
//  - A transfer with last_sample set raises busy and starts binning. Each
//    stored sample passes a store read, a multiply by the bin count, seven
//    steps of the shared restoring divider plus its done flag, and a
//    read-modify-write of the bin count memory before the next is fetched.
//  - Then one result per bin leaves on rsp_valid/rsp_data, each through a
//    count memory read, then the output register. busy drops as the final
//    result is driven, and the run state is cleared.
//  - rsp_valid is a one-cycle strobe; the receiver cannot stall it.
//  - csr_wr_en writes num_bins; write it only while busy is low and no set
//    is being loaded. Zero bins act as one bin, above 64 as 64.
//  - Reset clears the run state, the count memory valid bits and sets
//    num_bins to 8; the sample store is not cleared.
// ============================================================================
module range_scaled_histogram_core
   import rsh_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [BINS_W-1:0] csr_wr_data
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SAMPLES);

   state_type                  state_ff, state_in;
   logic [BINS_W-1:0]          num_bins_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic                       drop_ff, drop_in;
   logic [RANGE_W-1:0]         range_ff, range_in;
   logic [BINS_W-1:0]          bins_ff, bins_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [BIN_IDX_W-1:0]       bin_ff, bin_in;
   logic [BIN_IDX_W-1:0]       emit_ff, emit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   // sample store
   logic signed [SAMPLE_W-1:0] store_ff [MAX_SAMPLES];
   logic signed [SAMPLE_W-1:0] store_rd_ff;
   logic                       store_wr;
   logic                       store_rd;

   logic                       accept;
   logic                       full;
   logic [BINS_W-1:0]          bins_use;
   logic [SAMPLE_W:0]          diff_wide;
   logic [SAMPLE_W:0]          range_wide;
   logic [PROD_W-1:0]          product;
   logic                       div_start;
   logic                       div_done;
   logic [QUOT_W-1:0]          quotient;
   logic [BIN_IDX_W-1:0]       bin_calc;
   cnt_ctrl_type               cnt_ctrl;
   logic [TOTAL_W-1:0]         cnt_rd_data;

   rsh_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (product),
      .denominator (range_ff),
      .done        (div_done),
      .quotient    (quotient)
   );

   rsh_bin_counter u_bin_counter (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cnt_ctrl),
      .rd_data (cnt_rd_data)
   );

   assign accept = start && (state_ff == ST_LOAD);
   assign full   = (count_ff == FULL_COUNT);

   // saturate the bin count into 1..MAX_BINS
   always_comb begin
      if (num_bins_ff == '0) begin
         bins_use = BINS_W'(1);
      end else if (num_bins_ff > BINS_W'(MAX_BINS)) begin
         bins_use = BINS_W'(MAX_BINS);
      end else begin
         bins_use = num_bins_ff;
      end
   end

   // offsets are non-negative and fit RANGE_W bits unsigned
   assign range_wide = {max_ff[SAMPLE_W-1], max_ff} - {min_ff[SAMPLE_W-1], min_ff};
   assign diff_wide  = {store_rd_ff[SAMPLE_W-1], store_rd_ff}
                     - {min_ff[SAMPLE_W-1], min_ff};
   assign product    = PROD_W'(diff_wide[RANGE_W-1:0]) * PROD_W'(bins_ff);

   // flat set goes to bin 0; quotient equal to bins folds into the last bin
   always_comb begin
      if (range_ff == '0) begin
         bin_calc = '0;
      end else if (quotient >= bins_ff) begin
         bin_calc = BIN_IDX_W'(bins_ff - 1'b1);
      end else begin
         bin_calc = quotient[BIN_IDX_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      drop_in      = drop_ff;
      range_in     = range_ff;
      bins_in      = bins_ff;
      idx_in       = idx_ff;
      bin_in       = bin_ff;
      emit_in      = emit_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      store_wr     = 1'b0;
      store_rd     = 1'b0;
      div_start    = 1'b0;
      cnt_ctrl     = '0;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (!full) begin
                  store_wr = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     min_in = req_data.sample;
                     max_in = req_data.sample;
                  end else begin
                     if (req_data.sample < min_ff) begin
                        min_in = req_data.sample;
                     end
                     if (req_data.sample > max_ff) begin
                        max_in = req_data.sample;
                     end
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last_sample) begin
                  state_in = ST_RANGE;
               end
            end
         end
         ST_RANGE: begin
            range_in = range_wide[RANGE_W-1:0];
            bins_in  = bins_use;
            idx_in   = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            store_rd = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               cnt_ctrl.rd_en   = 1'b1;
               cnt_ctrl.rd_addr = bin_calc;
               bin_in           = bin_calc;
               state_in         = ST_CNT_WR;
            end
         end
         ST_CNT_WR: begin
            cnt_ctrl.wr_en   = 1'b1;
            cnt_ctrl.wr_addr = bin_ff;
            cnt_ctrl.wr_data = cnt_rd_data + 1'b1;
            if (idx_ff + 1'b1 == count_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_EMIT_RD: begin
            cnt_ctrl.rd_en   = 1'b1;
            cnt_ctrl.rd_addr = emit_ff;
            state_in         = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            cnt_ctrl.clr_en        = 1'b1;
            cnt_ctrl.wr_addr       = emit_ff;
            rsp_valid_in           = 1'b1;
            rsp_data_in.bin_index  = emit_ff;
            rsp_data_in.bin_total  = cnt_rd_data;
            rsp_data_in.overflowed = drop_ff;
            if ({1'b0, emit_ff} == bins_ff - 1'b1) begin
               // final bin: drop the run state and reopen loading
               rsp_data_in.last_bin = 1'b1;
               count_in             = '0;
               min_in               = '0;
               max_in               = '0;
               drop_in              = 1'b0;
               state_in             = ST_LOAD;
            end else begin
               rsp_data_in.last_bin = 1'b0;
               emit_in              = emit_ff + 1'b1;
               state_in             = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         num_bins_ff  <= BINS_W'(NUM_BINS_RESET);
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_bins_ff <= csr_wr_data;
         end
      end
      range_ff    <= range_in;
      bins_ff     <= bins_in;
      idx_ff      <= idx_in;
      bin_ff      <= bin_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample store: write while loading, registered read while binning
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[count_ff[ADDR_W-1:0]] <= req_data.sample;
      end
      if (store_rd) begin
         store_rd_ff <= store_ff[idx_ff[ADDR_W-1:0]];
      end
   end

   assign busy      = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
